[src/rld_pkg.sv]
// ----------------------------------------------------------------------------
// rld_pkg
// Shared types and constants of the run-length decoder.
// ----------------------------------------------------------------------------
package rld_pkg;

    // Length byte that marks end of data
    localparam logic [7:0] EOD_MARK    = 8'd128;
    // Repeat count is REPEAT_BIAS minus the length byte
    localparam logic [8:0] REPEAT_BIAS = 9'd257;

    // Default number of commands held between front and back
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    // Error codes of a result
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_LITERAL = 2'd1;
    localparam logic [1:0] ERR_REPEAT  = 2'd2;

    // Byte counts of a result
    localparam logic [1:0] CNT_NONE = 2'd0;
    localparam logic [1:0] CNT_ONE  = 2'd1;
    localparam logic [1:0] CNT_TWO  = 2'd2;

    // One command from front to back: either a ready result or a repeat run
    typedef struct packed {
        logic       is_repeat;
        logic [7:0] data_byte;
        logic [1:0] byte_count;
        logic       end_of_data;
        logic [1:0] error_code;
        logic [7:0] repeat_total;
    } rld_cmd_t;

    // Push side of the queue
    typedef struct packed {
        logic     valid;
        rld_cmd_t cmd;
    } rld_push_t;

endpackage

[src/rld_front.sv]
// ----------------------------------------------------------------------------
// rld_front
// Accepts encoded bytes, tracks the run header and issues commands.
// ----------------------------------------------------------------------------
module rld_front
    import rld_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] encoded_byte,
    input  logic       stream_end,
    input  logic       queue_full,
    output rld_push_t  push
);

    typedef enum logic [3:0] {
        PH_LEN  = 4'b0001,
        PH_LIT  = 4'b0010,
        PH_REP  = 4'b0100,
        PH_DONE = 4'b1000
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] lit_rem_reg, lit_rem_next;
    logic [7:0] rep_total_reg, rep_total_next;
    logic [7:0] lit_dec;
    logic       accept;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    // Classify the accepted item and build the command
    always_comb
    begin
        phase_next     = phase_reg;
        lit_rem_next   = lit_rem_reg;
        rep_total_next = rep_total_reg;
        push           = '0;
        lit_dec        = (lit_rem_reg != 8'd0) ? lit_rem_reg - 8'd1 : 8'd0;
        if (accept)
        begin
            case (phase_reg)
                PH_LEN:
                begin
                    if (encoded_byte == EOD_MARK)
                    begin
                        push.valid           = 1'b1;
                        push.cmd.end_of_data = 1'b1;
                        phase_next           = PH_DONE;
                    end
                    else if (encoded_byte < EOD_MARK)
                    begin
                        lit_rem_next = encoded_byte + 8'd1;
                        phase_next   = PH_LIT;
                        if (stream_end)
                        begin
                            push.valid          = 1'b1;
                            push.cmd.error_code = ERR_LITERAL;
                        end
                    end
                    else
                    begin
                        rep_total_next = 8'(REPEAT_BIAS - {1'b0, encoded_byte});
                        phase_next     = PH_REP;
                        if (stream_end)
                        begin
                            push.valid          = 1'b1;
                            push.cmd.error_code = ERR_REPEAT;
                        end
                    end
                end
                PH_LIT:
                begin
                    lit_rem_next        = lit_dec;
                    if (lit_dec == 8'd0)
                        phase_next = PH_LEN;
                    push.valid          = 1'b1;
                    push.cmd.data_byte  = encoded_byte;
                    push.cmd.byte_count = CNT_ONE;
                    push.cmd.error_code = (stream_end && lit_dec != 8'd0) ?
                                          ERR_LITERAL : ERR_NONE;
                end
                PH_REP:
                begin
                    push.valid            = 1'b1;
                    push.cmd.is_repeat    = 1'b1;
                    push.cmd.data_byte    = encoded_byte;
                    push.cmd.repeat_total = rep_total_reg;
                    rep_total_next        = 8'd0;
                    phase_next            = PH_LEN;
                end
                default:
                begin
                    // After end of data: drop the item
                end
            endcase
            // Start a new stream after the last byte
            if (stream_end)
            begin
                phase_next     = PH_LEN;
                lit_rem_next   = 8'd0;
                rep_total_next = 8'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_LEN;
            lit_rem_reg   <= 8'd0;
            rep_total_reg <= 8'd0;
        end
        else
        begin
            phase_reg     <= phase_next;
            lit_rem_reg   <= lit_rem_next;
            rep_total_reg <= rep_total_next;
        end
    end

endmodule

[src/rld_queue.sv]
// ----------------------------------------------------------------------------
// rld_queue
// Short command queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module rld_queue
    import rld_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  rld_push_t push,
    output logic      full,
    output logic      empty,
    input  logic      pop,
    output rld_cmd_t  head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rld_cmd_t           entry_mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push.valid && !full;
    assign do_pop  = pop && !empty;
    assign head    = entry_mem[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (!do_push && do_pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed command
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_mem[wr_ptr_reg] <= push.cmd;
    end

endmodule

[src/rld_back.sv]
// ----------------------------------------------------------------------------
// rld_back
// Carries out commands: passes single results, expands repeat runs in pairs.
// ----------------------------------------------------------------------------
module rld_back
    import rld_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       empty,
    input  rld_cmd_t   head,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] first_byte,
    output logic [7:0] second_byte,
    output logic [1:0] byte_count,
    output logic       end_of_data,
    output logic [1:0] error_code,
    output logic       last_of_run
);

    logic       out_valid_reg, out_valid_next;
    logic [7:0] first_reg, first_next;
    logic [7:0] second_reg, second_next;
    logic [1:0] count_reg, count_next;
    logic       eod_reg, eod_next;
    logic [1:0] err_reg, err_next;
    logic       last_reg, last_next;
    logic       rep_active_reg, rep_active_next;
    logic [7:0] rep_left_reg, rep_left_next;
    logic [7:0] rep_byte_reg, rep_byte_next;
    logic       can_load;

    assign can_load = !out_valid_reg || out_ready;
    assign pop      = can_load && !rep_active_reg && !empty;

    // Load the output register from the run in progress or the queue head
    always_comb
    begin
        out_valid_next  = out_valid_reg && !out_ready;
        first_next      = first_reg;
        second_next     = second_reg;
        count_next      = count_reg;
        eod_next        = eod_reg;
        err_next        = err_reg;
        last_next       = last_reg;
        rep_active_next = rep_active_reg;
        rep_left_next   = rep_left_reg;
        rep_byte_next   = rep_byte_reg;
        if (can_load)
        begin
            if (rep_active_reg)
            begin
                out_valid_next = 1'b1;
                first_next     = rep_byte_reg;
                eod_next       = 1'b0;
                err_next       = ERR_NONE;
                if (rep_left_reg >= 8'd2)
                begin
                    second_next     = rep_byte_reg;
                    count_next      = CNT_TWO;
                    last_next       = (rep_left_reg == 8'd2);
                    rep_active_next = (rep_left_reg != 8'd2);
                    rep_left_next   = rep_left_reg - 8'd2;
                end
                else
                begin
                    second_next     = 8'd0;
                    count_next      = CNT_ONE;
                    last_next       = 1'b1;
                    rep_active_next = 1'b0;
                    rep_left_next   = 8'd0;
                end
            end
            else if (!empty)
            begin
                if (head.is_repeat)
                begin
                    // Hold the run; pairs go out from the next cycle
                    rep_active_next = 1'b1;
                    rep_left_next   = head.repeat_total;
                    rep_byte_next   = head.data_byte;
                end
                else
                begin
                    out_valid_next = 1'b1;
                    first_next     = head.data_byte;
                    second_next    = 8'd0;
                    count_next     = head.byte_count;
                    eod_next       = head.end_of_data;
                    err_next       = head.error_code;
                    last_next      = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            rep_active_reg <= 1'b0;
            rep_left_reg   <= 8'd0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            rep_active_reg <= rep_active_next;
            rep_left_reg   <= rep_left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg    <= first_next;
        second_reg   <= second_next;
        count_reg    <= count_next;
        eod_reg      <= eod_next;
        err_reg      <= err_next;
        last_reg     <= last_next;
        rep_byte_reg <= rep_byte_next;
    end

    assign out_valid   = out_valid_reg;
    assign first_byte  = first_reg;
    assign second_byte = second_reg;
    assign byte_count  = count_reg;
    assign end_of_data = eod_reg;
    assign error_code  = err_reg;
    assign last_of_run = last_reg;

endmodule

[src/run_length_decoder_core.sv]
// ----------------------------------------------------------------------------
// run_length_decoder_core
// Run-length (PackBits style) stream decoder, one encoded byte per item.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one encoded byte per item, stream_end
// set on the last byte of a stream. Output channel (out_valid/out_ready):
// one result per item with up to two decoded bytes, the end-of-data flag,
// an error code and last_of_run on the final result of each input byte.
// Header and literal bytes are taken one per cycle while the command queue
// has room. A repeat byte first starts its run in the back end, which then
// sends it out as pairs of bytes, a single last byte for an odd count;
// the front keeps taking bytes until the command queue (QUEUE_DEPTH
// entries) fills. An accepted item passes through the command queue and
// then into the output register before its first result; a repeat byte
// first starts its run in the back end after it leaves the queue.
// Reset clears the decoder phase, the queue and the output valid, so the
// next byte is read as a length byte. When the receiver stalls, the result
// holds in the output register, the back end stops, the queue fills and
// in_ready drops.
// ----------------------------------------------------------------------------
module run_length_decoder_core
    import rld_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] encoded_byte,
    input  logic       stream_end,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] first_byte,
    output logic [7:0] second_byte,
    output logic [1:0] byte_count,
    output logic       end_of_data,
    output logic [1:0] error_code,
    output logic       last_of_run
);

    rld_push_t push;
    rld_cmd_t  head;
    logic      queue_full;
    logic      queue_empty;
    logic      pop;

    // Accept and classify bytes
    rld_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .encoded_byte (encoded_byte),
        .stream_end   (stream_end),
        .queue_full   (queue_full),
        .push         (push)
    );

    // Hold commands between front and back
    rld_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (queue_full),
        .empty (queue_empty),
        .pop   (pop),
        .head  (head)
    );

    // Produce results
    rld_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .empty       (queue_empty),
        .head        (head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .first_byte  (first_byte),
        .second_byte (second_byte),
        .byte_count  (byte_count),
        .end_of_data (end_of_data),
        .error_code  (error_code),
        .last_of_run (last_of_run)
    );

endmodule

[src/rld_checker.sv]
// ----------------------------------------------------------------------------
// rld_checker
// Port-level checks of the run-length decoder, bound to the top level.
// ----------------------------------------------------------------------------
module rld_checker
    import rld_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] first_byte,
    input logic [7:0] second_byte,
    input logic [1:0] byte_count,
    input logic       end_of_data,
    input logic [1:0] error_code,
    input logic       last_of_run
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(first_byte)
        && $stable(second_byte) && $stable(byte_count) && $stable(end_of_data)
        && $stable(error_code) && $stable(last_of_run))
        else $error("result changed while stalled");

    // Status-only results end their run
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && byte_count == CNT_NONE |-> last_of_run && first_byte == 8'd0)
        else $error("status result not marked last");

    // End of data carries no bytes and no error
    a_eod_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_of_data |-> byte_count == CNT_NONE && error_code == ERR_NONE)
        else $error("bad end-of-data result");

    // Pairs come only from repeat runs
    a_pair_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && byte_count == CNT_TWO |->
        error_code == ERR_NONE && !end_of_data && first_byte == second_byte)
        else $error("bad repeat pair");

    // Byte count is in range, and results other than pairs carry no second byte
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (byte_count == CNT_NONE || byte_count == CNT_ONE
        || byte_count == CNT_TWO) && (byte_count == CNT_TWO || second_byte == 8'd0))
        else $error("byte count out of range");

endmodule

bind run_length_decoder_core rld_checker u_rld_checker (.*);
